// ===== src/lmc_pkg.sv =====
// Package for the LED mode controller: mode codes, colours, register indexes and colour choice.
`default_nettype none
package lmc_pkg;

	typedef logic [3:0]  mode_t;
	typedef logic [23:0] color_t;
	typedef logic [2:0]  reg_idx_t;

	localparam mode_t MODE_OFF        = 4'd0;
	localparam mode_t MODE_ON         = 4'd1;
	localparam mode_t MODE_BLINK_SLOW = 4'd2;
	localparam mode_t MODE_BLINK_FAST = 4'd3;
	localparam mode_t MODE_BREATHE    = 4'd4;
	localparam mode_t MODE_WHITE      = 4'd5;
	localparam mode_t MODE_BLUE       = 4'd6;
	localparam mode_t MODE_GREEN      = 4'd7;
	localparam mode_t MODE_YELLOW     = 4'd8;

	localparam logic CMD_TICK = 1'b0;
	localparam logic CMD_SET  = 1'b1;

	localparam reg_idx_t REG_RGB_MASK   = 3'd0;
	localparam reg_idx_t REG_WHITE      = 3'd1;
	localparam reg_idx_t REG_SLOW       = 3'd2;
	localparam reg_idx_t REG_FAST       = 3'd3;
	localparam reg_idx_t REG_BRIGHTNESS = 3'd4;

	localparam color_t COLOR_YELLOW = 24'hFFA000;
	localparam color_t COLOR_BLUE   = 24'h0000FF;
	localparam color_t COLOR_GREEN  = 24'h00FF00;
	localparam color_t COLOR_BLACK  = 24'h000000;

	localparam logic [3:0] TICKS_LONG  = 4'd8;
	localparam logic [3:0] TICKS_SHORT = 4'd4;

	typedef struct packed {
		logic   on;
		color_t color;
	} shade_t;

	// Level and colour for a mode; blink_on is the phase test of the mode's period.
	function automatic shade_t pick_shade(mode_t mode, logic blink_on, color_t white);
		shade_t s;
		s.on    = 1'b1;
		s.color = white;
		case (mode)
			MODE_ON, MODE_BREATHE, MODE_WHITE: ;
			MODE_BLINK_SLOW: s.on = blink_on;
			MODE_BLINK_FAST: begin
				s.on    = blink_on;
				s.color = COLOR_YELLOW;
			end
			MODE_BLUE:   s.color = COLOR_BLUE;
			MODE_GREEN:  s.color = COLOR_GREEN;
			MODE_YELLOW: s.color = COLOR_YELLOW;
			default:     s.on = 1'b0;
		endcase
		if (!s.on)
			s.color = COLOR_BLACK;
		return s;
	endfunction

endpackage
`default_nettype wire

// ===== src/led_mode_controller_ws2812.sv =====
// LED mode controller top level: slot memories, phase divider and WS2812 bit sequencer.
//
// channel   signals                                   handshake
// command   command led_slot now_ms new_mode          start && !busy
//           hold_ms expiry_mode
// result    out_slot is_pulse gpio_level high_ticks   strobe, one cycle, no stall
//           low_ticks last_of_run
// config    wr_en wr_index wr_data                    wr_en, no wait
//
// A set transaction is written to the slot memory at its accept edge; busy stays low.
// A tick reads the slot memories at its accept edge, tests expiry (ST_EXP), runs the
// restoring remainder unit on now_ms (ST_DIV) and picks the colour (ST_COL).
// GPIO slot: level result in the next cycle. RGB slot: no result if the colour equals the
// last one sent, else scale (ST_SCL), then 24 results back to back. The receiver cannot stall.
// Reset clears the valid bits of every slot entry.
`default_nettype none
module led_mode_controller_ws2812 #(
	parameter int NUM_SLOTS = 4
) (
	input  wire                   clk,
	input  wire                   arst_n,
	input  wire                   start,
	output logic                  busy,
	input  wire                   command,
	input  wire  [1:0]            led_slot,
	input  wire  [31:0]           now_ms,
	input  wire  lmc_pkg::mode_t  new_mode,
	input  wire  [31:0]           hold_ms,
	input  wire  lmc_pkg::mode_t  expiry_mode,
	input  wire                   wr_en,
	input  wire  lmc_pkg::reg_idx_t wr_index,
	input  wire  [23:0]           wr_data,
	output logic                  strobe,
	output logic [1:0]            out_slot,
	output logic                  is_pulse,
	output logic                  gpio_level,
	output logic [3:0]            high_ticks,
	output logic [3:0]            low_ticks,
	output logic                  last_of_run
);
	import lmc_pkg::*;

	localparam int SW = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;

	localparam logic [2:0] ST_IDLE = 3'd0;
	localparam logic [2:0] ST_EXP  = 3'd1;
	localparam logic [2:0] ST_DIV  = 3'd2;
	localparam logic [2:0] ST_COL  = 3'd3;
	localparam logic [2:0] ST_SCL  = 3'd4;
	localparam logic [2:0] ST_SEND = 3'd5;

	typedef struct packed {
		mode_t       mode;
		logic [31:0] start_time;
		logic [31:0] duration;
		mode_t       fallback;
	} slot_ent_t;

	// configuration
	logic [3:0]  rgb_mask_q;
	color_t      white_q;
	logic [15:0] slow_q;
	logic [15:0] fast_q;
	logic [7:0]  bright_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rgb_mask_q <= 4'd0;
			white_q    <= 24'hFFFFFF;
			slow_q     <= 16'd1000;
			fast_q     <= 16'd200;
			bright_q   <= 8'd128;
		end else if (wr_en) begin
			case (wr_index)
				REG_RGB_MASK:   rgb_mask_q <= wr_data[3:0];
				REG_WHITE:      white_q    <= wr_data;
				REG_SLOW:       slow_q     <= wr_data[15:0];
				REG_FAST:       fast_q     <= wr_data[15:0];
				REG_BRIGHTNESS: bright_q   <= wr_data[7:0];
				default: ;
			endcase
		end
	end

	logic [2:0] state_q;
	logic       accept, slot_ok, tick_go, set_go;
	logic [SW-1:0] idx_in;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && !busy;
	assign slot_ok = (32'(led_slot) < NUM_SLOTS);
	assign tick_go = accept && slot_ok && (command == CMD_TICK);
	assign set_go  = accept && slot_ok && (command == CMD_SET);
	assign idx_in  = SW'(led_slot);

	// slot memories; entries without a valid bit read as the reset value
	slot_ent_t mode_mem [NUM_SLOTS];
	color_t    sent_mem [NUM_SLOTS];
	logic [NUM_SLOTS-1:0] mode_ok_q, sent_ok_q;

	logic [SW-1:0] idx_q;
	logic [1:0]    slot_q;
	logic [31:0]   now_q;
	slot_ent_t     ent_s1;
	logic          ent_ok_s1;
	color_t        sent_s1;
	logic          sent_ok_s1;

	// item working registers
	mode_t       mode_q;
	logic        exp_q;
	logic [31:0] start_keep_q;
	mode_t       fb_keep_q;
	logic [15:0] p_q;
	logic [15:0] rem_q;
	logic [31:0] div_sh_q;
	logic [4:0]  cnt_q;
	color_t      color_q;
	logic [23:0] grb_q;

	logic      mem_we;
	slot_ent_t mem_wdata;
	logic [SW-1:0] mem_waddr;
	logic      sent_we;

	slot_ent_t   ent_eff;
	mode_t       mode_eff;
	logic        expired;
	logic [31:0] elapsed;
	logic [15:0] period;
	logic [16:0] trial;
	logic        blink_on;
	shade_t      shade;
	logic        is_rgb, unchanged;
	logic [15:0] prod_r, prod_g, prod_b;

	always_comb begin
		ent_eff  = ent_ok_s1 ? ent_s1 : '0;
		elapsed  = now_q - ent_eff.start_time;
		expired  = (ent_eff.duration != 32'd0) && (elapsed >= ent_eff.duration);
		mode_eff = expired ? ent_eff.fallback : ent_eff.mode;
		period   = (mode_eff == MODE_BLINK_FAST) ? fast_q : slow_q;
		if (period == 16'd0)
			period = 16'd1;
		trial     = {rem_q, div_sh_q[31]};
		blink_on  = (rem_q < (p_q >> 1));
		shade     = pick_shade(mode_q, blink_on, white_q);
		is_rgb    = rgb_mask_q[slot_q];
		unchanged = sent_ok_s1 && (sent_s1 == shade.color);
		prod_r    = color_q[23:16] * bright_q;
		prod_g    = color_q[15:8]  * bright_q;
		prod_b    = color_q[7:0]   * bright_q;
	end

	// one write port: set at accept, expiry write-back in the colour step
	always_comb begin
		mem_we    = set_go || (state_q == ST_COL && exp_q);
		mem_waddr = set_go ? idx_in : idx_q;
		if (set_go) begin
			mem_wdata.mode       = new_mode;
			mem_wdata.start_time = now_ms;
			mem_wdata.duration   = hold_ms;
			mem_wdata.fallback   = expiry_mode;
		end else begin
			mem_wdata.mode       = mode_q;
			mem_wdata.start_time = start_keep_q;
			mem_wdata.duration   = 32'd0;
			mem_wdata.fallback   = fb_keep_q;
		end
		sent_we = (state_q == ST_COL) && is_rgb && !unchanged;
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			mode_mem[mem_waddr] <= mem_wdata;
		if (sent_we)
			sent_mem[idx_q] <= shade.color;
		if (tick_go) begin
			ent_s1  <= mode_mem[idx_in];
			sent_s1 <= sent_mem[idx_in];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_ok_q <= '0;
			sent_ok_q <= '0;
		end else begin
			if (mem_we)
				mode_ok_q[mem_waddr] <= 1'b1;
			if (sent_we)
				sent_ok_q[idx_q] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (tick_go) begin
			idx_q      <= idx_in;
			slot_q     <= led_slot;
			now_q      <= now_ms;
			ent_ok_s1  <= mode_ok_q[idx_in];
			sent_ok_s1 <= sent_ok_q[idx_in];
		end
		case (state_q)
			ST_EXP: begin
				mode_q       <= mode_eff;
				exp_q        <= expired;
				start_keep_q <= ent_eff.start_time;
				fb_keep_q    <= ent_eff.fallback;
				p_q          <= period;
				rem_q        <= 16'd0;
				div_sh_q     <= now_q;
				cnt_q        <= 5'd0;
			end
			ST_DIV: begin
				if (trial >= {1'b0, p_q})
					rem_q <= 16'(trial - {1'b0, p_q});
				else
					rem_q <= trial[15:0];
				div_sh_q <= {div_sh_q[30:0], 1'b0};
				cnt_q    <= cnt_q + 5'd1;
			end
			ST_COL: begin
				color_q <= shade.color;
				cnt_q   <= 5'd0;
			end
			ST_SCL: grb_q <= {prod_g[15:8], prod_r[15:8], prod_b[15:8]};
			ST_SEND: begin
				grb_q <= {grb_q[22:0], 1'b0};
				cnt_q <= cnt_q + 5'd1;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			case (state_q)
				ST_IDLE: if (tick_go) state_q <= ST_EXP;
				ST_EXP:  state_q <= ST_DIV;
				ST_DIV:  if (cnt_q == 5'd31) state_q <= ST_COL;
				ST_COL:  state_q <= (is_rgb && !unchanged) ? ST_SCL : ST_IDLE;
				ST_SCL:  state_q <= ST_SEND;
				ST_SEND: if (cnt_q == 5'd23) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// result register
	logic gpio_res, pulse_res;
	assign gpio_res  = (state_q == ST_COL) && !is_rgb;
	assign pulse_res = (state_q == ST_SEND);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			strobe <= 1'b0;
		else
			strobe <= gpio_res || pulse_res;
	end

	always_ff @(posedge clk) begin
		if (gpio_res) begin
			out_slot    <= slot_q;
			is_pulse    <= 1'b0;
			gpio_level  <= shade.on;
			high_ticks  <= 4'd0;
			low_ticks   <= 4'd0;
			last_of_run <= 1'b1;
		end else if (pulse_res) begin
			out_slot    <= slot_q;
			is_pulse    <= 1'b1;
			gpio_level  <= 1'b0;
			high_ticks  <= grb_q[23] ? TICKS_LONG : TICKS_SHORT;
			low_ticks   <= grb_q[23] ? TICKS_SHORT : TICKS_LONG;
			last_of_run <= (cnt_q == 5'd23);
		end
	end

	a_rem_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_COL) |-> (rem_q < p_q))
		else $error("remainder not below period");

	a_gpio_single: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && !is_pulse) |-> last_of_run)
		else $error("GPIO result not last of run");

	a_pulse_ticks: assert property (@(posedge clk) disable iff (!arst_n)
		(strobe && is_pulse) |->
		((high_ticks == TICKS_LONG && low_ticks == TICKS_SHORT) ||
		 (high_ticks == TICKS_SHORT && low_ticks == TICKS_LONG)))
		else $error("bad pulse pair");

	a_run_end: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_SEND && cnt_q == 5'd23) |=> (strobe && last_of_run && !busy))
		else $error("pulse run did not close");

	a_no_idle_write: assert property (@(posedge clk) disable iff (!arst_n)
		(mem_we && !set_go) |-> (state_q == ST_COL && exp_q))
		else $error("stray slot memory write");

endmodule
`default_nettype wire
